// ----- hw/rtl/fwh_pkg.sv -----
package fwh_pkg;

    localparam int MAX_BINS = 64;
    localparam int BIN_AW   = $clog2(MAX_BINS);
    localparam int NB_W     = $clog2(MAX_BINS + 1);
    // common width for comparing the 7-bit register against MAX_BINS
    localparam int NBC_W    = (NB_W > 7) ? NB_W : 7;

    localparam int VAL_W     = 32;
    localparam int BIN_W     = 48;
    localparam int SUM_W     = 56;
    localparam int IDX_OUT_W = 6;
    localparam int CFG_IDX_W = 8;

    localparam logic [VAL_W-1:0] UNIT_WEIGHT = 32'h0001_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BOUND       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_BIN_WIDTH   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS        = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_WEIGHT      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE   = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_LOW      = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_HIGH     = 8'd6;

    typedef struct packed {
        logic [VAL_W-1:0] low_bound;
        logic [VAL_W-1:0] inv_bin_width;
        logic [6:0]       num_bins;
        logic             use_weight;
        logic             filter_enable;
        logic [VAL_W-1:0] filter_low;
        logic [VAL_W-1:0] filter_high;
    } cfg_t;

    // bin update request leaving the index pipe (also drives the RAM read)
    typedef struct packed {
        logic              valid;
        logic [BIN_AW-1:0] addr;
        logic [VAL_W-1:0]  add;
    } bin_req_t;

    typedef struct packed {
        logic              en;
        logic [BIN_AW-1:0] addr;
        logic [BIN_W-1:0]  data;
    } bin_wr_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAIN,
        ST_READ,
        ST_OUT
    } state_t;

endpackage

// ----- hw/rtl/fwh_ram.sv -----
module fwh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old entry on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/fwh_index_pipe.sv -----
module fwh_index_pipe
    import fwh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [VAL_W-1:0]  in_value,
    input  logic [VAL_W-1:0]  in_weight,
    input  logic              in_covered,
    input  logic [VAL_W-1:0]  in_fval,
    input  cfg_t              cfg,
    input  logic [NB_W-1:0]   nb,
    output bin_req_t          req,
    output logic              busy
);

    // stage A: captured sample
    logic              a_valid_reg;
    logic [VAL_W-1:0]  a_value_reg;
    logic [VAL_W-1:0]  a_weight_reg;
    logic              a_covered_reg;
    logic [VAL_W-1:0]  a_fval_reg;

    // stage B: offset magnitude and weight
    logic              b_valid_reg;
    logic              b_valid_next;
    logic [VAL_W-1:0]  b_dmag_reg;
    logic [VAL_W-1:0]  b_dmag_next;
    logic [VAL_W-1:0]  b_add_reg;
    logic [VAL_W-1:0]  b_add_next;

    // stage C: raw bin index
    logic              c_valid_reg;
    logic [VAL_W-1:0]  c_idx_reg;
    logic [VAL_W-1:0]  c_add_reg;

    logic [VAL_W:0]     diff;
    logic               neg;
    logic               filt_ok;
    logic [2*VAL_W-1:0] prod;
    logic               hit_last;
    logic               in_range;

    always_comb begin
        diff    = {a_value_reg[VAL_W-1], a_value_reg}
                - {cfg.low_bound[VAL_W-1], cfg.low_bound};
        neg     = diff[VAL_W];
        filt_ok = !cfg.filter_enable
               || (($signed(a_fval_reg) >= $signed(cfg.filter_low))
                && ($signed(a_fval_reg) <= $signed(cfg.filter_high)));
        // negative offset lands in bin 0 only when the scale is zero
        b_valid_next = a_valid_reg && !a_covered_reg && filt_ok
                    && (!neg || (cfg.inv_bin_width == '0));
        b_dmag_next  = neg ? '0 : diff[VAL_W-1:0];
        b_add_next   = cfg.use_weight ? a_weight_reg : UNIT_WEIGHT;
    end

    assign prod = b_dmag_reg * cfg.inv_bin_width;

    always_comb begin
        hit_last  = (c_idx_reg == 32'(nb));
        in_range  = (c_idx_reg < 32'(nb));
        req.valid = c_valid_reg && (hit_last || in_range);
        req.addr  = hit_last ? BIN_AW'(nb - NB_W'(1)) : c_idx_reg[BIN_AW-1:0];
        req.add   = c_add_reg;
    end

    assign busy = a_valid_reg || b_valid_reg || c_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= in_valid;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= b_valid_reg;
        end
        a_value_reg   <= in_value;
        a_weight_reg  <= in_weight;
        a_covered_reg <= in_covered;
        a_fval_reg    <= in_fval;
        b_dmag_reg    <= b_dmag_next;
        b_add_reg     <= b_add_next;
        c_idx_reg     <= prod[2*VAL_W-1:VAL_W];
        c_add_reg     <= b_add_reg;
    end

endmodule

// ----- hw/rtl/fwh_accum.sv -----
module fwh_accum
    import fwh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  bin_req_t          req,
    input  logic [BIN_W-1:0]  rdata,
    input  logic              total_clr,
    output bin_wr_t           wr,
    output logic [SUM_W-1:0]  total,
    output logic              busy
);

    logic              d_valid_reg;
    logic [BIN_AW-1:0] d_addr_reg;
    logic [VAL_W-1:0]  d_add_reg;

    // last write, for an entry read before that write landed
    logic              fwd_valid_reg;
    logic [BIN_AW-1:0] fwd_addr_reg;
    logic [BIN_W-1:0]  fwd_data_reg;

    logic [SUM_W-1:0]  total_reg;
    logic [SUM_W-1:0]  total_next;

    logic [BIN_W-1:0]  old_bin;
    logic [BIN_W:0]    bin_sum;
    logic [BIN_W-1:0]  new_bin;
    logic [SUM_W:0]    tot_sum;

    always_comb begin
        old_bin = (fwd_valid_reg && (fwd_addr_reg == d_addr_reg)) ? fwd_data_reg : rdata;
        bin_sum = {1'b0, old_bin} + (BIN_W + 1)'(d_add_reg);
        new_bin = bin_sum[BIN_W] ? '1 : bin_sum[BIN_W-1:0];
        tot_sum = {1'b0, total_reg} + (SUM_W + 1)'(d_add_reg);
        if (total_clr) begin
            total_next = '0;
        end else if (d_valid_reg) begin
            total_next = tot_sum[SUM_W] ? '1 : tot_sum[SUM_W-1:0];
        end else begin
            total_next = total_reg;
        end
    end

    assign wr.en   = d_valid_reg;
    assign wr.addr = d_addr_reg;
    assign wr.data = new_bin;
    assign total   = total_reg;
    assign busy    = d_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            total_reg     <= '0;
        end else begin
            d_valid_reg   <= req.valid;
            fwd_valid_reg <= d_valid_reg;
            total_reg     <= total_next;
        end
        d_addr_reg   <= req.addr;
        d_add_reg    <= req.add;
        fwd_addr_reg <= d_addr_reg;
        fwd_data_reg <= new_bin;
    end

endmodule

// ----- hw/rtl/filtered_weighted_histogram.sv -----
// channel   direction  payload
// s_        in         command, sample_value, sample_weight, covered, filter_value
// m_        out        bin_index, bin_total, grand_total, last (one per bin in use on readout)
// cfg_      in         cfg_index, cfg_data (register write)
//
// Add samples: one per cycle while s_ready is high; a sample is binned by the stages
// subtract/filter, multiply, index/RAM read, add/write-back with forwarding.
// Readout: waits for the add pipe to drain, then sweeps all MAX_BINS entries, each
// through a READ state (RAM read + clear) and an OUT state (output) that holds for
// any m_ stall. s_ready is low for the whole readout.
// After reset a clearing pass over all MAX_BINS entries runs with s_ready low;
// cfg_ writes are taken at any time.
module filtered_weighted_histogram
    import fwh_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_command,
    input  logic signed [VAL_W-1:0]  s_sample_value,
    input  logic [VAL_W-1:0]         s_sample_weight,
    input  logic                     s_covered,
    input  logic signed [VAL_W-1:0]  s_filter_value,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [IDX_OUT_W-1:0]     m_bin_index,
    output logic [BIN_W-1:0]         m_bin_total,
    output logic [SUM_W-1:0]         m_grand_total,
    output logic                     m_last,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [VAL_W-1:0]         cfg_data
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    state_t state_reg;
    state_t state_next;

    logic [BIN_AW-1:0] k_reg;
    logic [BIN_AW-1:0] k_next;

    logic                 m_valid_reg;
    logic [IDX_OUT_W-1:0] m_bin_index_reg;
    logic [BIN_W-1:0]     m_bin_total_reg;
    logic [SUM_W-1:0]     m_grand_total_reg;
    logic                 m_last_reg;

    logic [NBC_W-1:0] nb_wide;
    logic [NB_W-1:0]  nb;

    bin_req_t acc_req;
    bin_wr_t  acc_wr;
    logic     pipe_busy;
    logic     acc_busy;
    logic     add_xfer;
    logic [SUM_W-1:0] acc_total;

    logic              ram_we;
    logic [BIN_AW-1:0] ram_waddr;
    logic [BIN_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [BIN_AW-1:0] ram_raddr;
    logic [BIN_W-1:0]  ram_rdata;

    logic sweep_last;
    logic emit;
    logic slot_free;
    logic advance;
    logic seq_we;
    logic seq_re;
    logic out_load;
    logic k_step;
    logic total_clr;
    logic add_path;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_LOW_BOUND:       cfg_next.low_bound       = cfg_data;
                CFG_INV_BIN_WIDTH:   cfg_next.inv_bin_width   = cfg_data;
                CFG_NUM_BINS:        cfg_next.num_bins        = cfg_data[6:0];
                CFG_USE_WEIGHT:      cfg_next.use_weight      = cfg_data[0];
                CFG_FILTER_ENABLE:   cfg_next.filter_enable   = cfg_data[0];
                CFG_FILTER_LOW:      cfg_next.filter_low      = cfg_data;
                CFG_FILTER_HIGH:     cfg_next.filter_high     = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // bins in use: zero acts as one, clamp at MAX_BINS
    always_comb begin
        nb_wide = NBC_W'(cfg_reg.num_bins);
        if (nb_wide == '0) begin
            nb_wide = NBC_W'(1);
        end else if (nb_wide > NBC_W'(MAX_BINS)) begin
            nb_wide = NBC_W'(MAX_BINS);
        end
        nb = NB_W'(nb_wide);
    end

    assign add_xfer = s_valid && s_ready && !s_command;

    fwh_index_pipe u_index (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (add_xfer),
        .in_value   (s_sample_value),
        .in_weight  (s_sample_weight),
        .in_covered (s_covered),
        .in_fval    (s_filter_value),
        .cfg        (cfg_reg),
        .nb         (nb),
        .req        (acc_req),
        .busy       (pipe_busy)
    );

    fwh_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (acc_req),
        .rdata     (ram_rdata),
        .total_clr (total_clr),
        .wr        (acc_wr),
        .total     (acc_total),
        .busy      (acc_busy)
    );

    fwh_ram #(
        .WIDTH (BIN_W),
        .DEPTH (MAX_BINS)
    ) u_bins (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sweep sequencer
    assign sweep_last = (k_reg == BIN_AW'(MAX_BINS - 1));
    assign emit       = (32'(k_reg) < 32'(nb));
    assign slot_free  = !m_valid_reg || m_ready;
    assign advance    = !emit || slot_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_command) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy && !acc_busy) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (advance) begin
                    state_next = sweep_last ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        add_path  = 1'b0;
        seq_we    = 1'b0;
        seq_re    = 1'b0;
        out_load  = 1'b0;
        k_step    = 1'b0;
        total_clr = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                seq_we = 1'b1;
                k_step = 1'b1;
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                add_path = 1'b1;
            end
            ST_DRAIN: begin
                add_path = 1'b1;
            end
            ST_READ: begin
                // read-first RAM: old total comes out while the entry clears
                seq_we = 1'b1;
                seq_re = 1'b1;
            end
            ST_OUT: begin
                out_load  = emit && slot_free;
                k_step    = advance;
                total_clr = advance && sweep_last;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (add_path) begin
            ram_we    = acc_wr.en;
            ram_waddr = acc_wr.addr;
            ram_wdata = acc_wr.data;
            ram_re    = acc_req.valid;
            ram_raddr = acc_req.addr;
        end else begin
            ram_we    = seq_we;
            ram_waddr = k_reg;
            ram_wdata = '0;
            ram_re    = seq_re;
            ram_raddr = k_reg;
        end
    end

    always_comb begin
        k_next = k_reg;
        if (k_step) begin
            k_next = sweep_last ? '0 : k_reg + BIN_AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
            cfg_reg.low_bound       <= '0;
            cfg_reg.inv_bin_width   <= 32'h0001_0000;
            cfg_reg.num_bins        <= 7'd64;
            cfg_reg.use_weight      <= 1'b0;
            cfg_reg.filter_enable   <= 1'b0;
            cfg_reg.filter_low      <= '0;
            cfg_reg.filter_high     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            cfg_reg   <= cfg_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (out_load) begin
            m_bin_index_reg   <= IDX_OUT_W'(k_reg);
            m_bin_total_reg   <= ram_rdata;
            m_grand_total_reg <= acc_total;
            m_last_reg        <= (32'(k_reg) + 32'd1 == 32'(nb));
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_bin_index   = m_bin_index_reg;
    assign m_bin_total   = m_bin_total_reg;
    assign m_grand_total = m_grand_total_reg;
    assign m_last        = m_last_reg;

    // sweep must never collide with an add write-back
    a_no_add_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR || state_reg == ST_READ || state_reg == ST_OUT)
            |-> !acc_wr.en)
        else $error("add write-back during bin sweep");

    a_drained_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (!pipe_busy && !acc_busy))
        else $error("readout started with samples in flight");

    a_total_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        total_clr |=> (acc_total == '0))
        else $error("grand total not cleared after readout");

endmodule

// ----- verif/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fwh_pkg::*;

    localparam int          ITEM_TARGET  = 270;
    localparam int          SETTLE_TICKS = 12;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    localparam int SETUP_NONE          = 0;
    localparam int SETUP_WIDE_WEIGHTED = 1;
    localparam int SETUP_EMPTY_FILTER  = 2;

    typedef struct {
        logic [IDX_OUT_W-1:0] bin_index;
        logic [BIN_W-1:0]     bin_total;
        logic [SUM_W-1:0]     grand_total;
        logic                 last;
    } bin_report_t;

    typedef struct {
        int          setup;
        bit          cmd;
        logic [31:0] value;
        logic [31:0] weight;
        bit          covered;
        logic [31:0] fval;
        bit          typed;
        int          typed_bin;
        logic [47:0] typed_total;
        logic [55:0] typed_grand;
    } dir_row_t;

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic                   s_command      = 1'b0;
    logic signed [VAL_W-1:0] s_sample_value = '0;
    logic [VAL_W-1:0]       s_sample_weight = '0;
    logic                   s_covered      = 1'b0;
    logic signed [VAL_W-1:0] s_filter_value = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [IDX_OUT_W-1:0]   m_bin_index;
    logic [BIN_W-1:0]       m_bin_total;
    logic [SUM_W-1:0]       m_grand_total;
    logic                   m_last;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index      = '0;
    logic [VAL_W-1:0]       cfg_data       = '0;

    cfg_t              shadow_cfg;
    logic [BIN_W-1:0]  bin_acc [MAX_BINS];
    logic [SUM_W-1:0]  total_acc;
    bin_report_t       report_q [$];
    dir_row_t          dir_rows [$];

    int          s_idle_pct  = 24;
    int          m_idle_pct  = 87;
    int          item_count  = 0;
    int          mismatches  = 0;
    int unsigned cycle_count = 0;

    filtered_weighted_histogram dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_sample_value (s_sample_value),
        .s_sample_weight(s_sample_weight),
        .s_covered      (s_covered),
        .s_filter_value (s_filter_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bin_index    (m_bin_index),
        .m_bin_total    (m_bin_total),
        .m_grand_total  (m_grand_total),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL filtered_weighted_histogram");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    // ---------------- histogram predictor ----------------

    function automatic int unsigned active_bins();
        int unsigned nb;
        nb = 32'(shadow_cfg.num_bins);
        if (nb == 0) nb = 1;
        if (nb > MAX_BINS) nb = MAX_BINS;
        return nb;
    endfunction

    function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
        case (idx)
            CFG_LOW_BOUND:       shadow_cfg.low_bound       = data;
            CFG_INV_BIN_WIDTH:   shadow_cfg.inv_bin_width   = data;
            CFG_NUM_BINS:        shadow_cfg.num_bins        = data[6:0];
            CFG_USE_WEIGHT:      shadow_cfg.use_weight      = data[0];
            CFG_FILTER_ENABLE:   shadow_cfg.filter_enable   = data[0];
            CFG_FILTER_LOW:      shadow_cfg.filter_low      = data;
            CFG_FILTER_HIGH:     shadow_cfg.filter_high     = data;
            default: ;
        endcase
    endfunction

    function automatic void bin_sample(logic [31:0] value, logic [31:0] weight, bit cov,
                                       logic [31:0] fval);
        logic signed [32:0] offset;
        logic [63:0]        prod;
        logic [31:0]        slot_idx;
        logic [31:0]        add;
        logic [BIN_W:0]     bsum;
        logic [SUM_W:0]     tsum;
        int unsigned        nb;
        nb = active_bins();
        if (cov) return;
        if (shadow_cfg.filter_enable &&
            ($signed(fval) < $signed(shadow_cfg.filter_low) ||
             $signed(fval) > $signed(shadow_cfg.filter_high))) return;
        offset = {value[31], value} - {shadow_cfg.low_bound[31], shadow_cfg.low_bound};
        if (offset < 0) begin
            // below the first edge only lands in bin 0 with a zero reciprocal
            if (shadow_cfg.inv_bin_width != 0) return;
            slot_idx = 0;
        end else begin
            prod = {32'd0, offset[31:0]} * {32'd0, shadow_cfg.inv_bin_width};
            slot_idx = prod[63:32];
        end
        if (slot_idx == nb) slot_idx = nb - 1;
        if (slot_idx >= nb) return;
        add = shadow_cfg.use_weight ? weight : UNIT_WEIGHT;
        bsum = {1'b0, bin_acc[slot_idx[BIN_AW-1:0]]} + (BIN_W + 1)'(add);
        bin_acc[slot_idx[BIN_AW-1:0]] = bsum[BIN_W] ? {BIN_W{1'b1}} : bsum[BIN_W-1:0];
        tsum = {1'b0, total_acc} + (SUM_W + 1)'(add);
        total_acc = tsum[SUM_W] ? {SUM_W{1'b1}} : tsum[SUM_W-1:0];
    endfunction

    function automatic void sweep_bins();
        bin_report_t rep;
        int unsigned nb;
        nb = active_bins();
        for (int unsigned k = 0; k < nb; k++) begin
            rep.bin_index   = IDX_OUT_W'(k);
            rep.bin_total   = bin_acc[k];
            rep.grand_total = total_acc;
            rep.last        = (k + 1 == nb);
            report_q.insert(report_q.size(), rep);
        end
        for (int k = 0; k < MAX_BINS; k++) bin_acc[k] = '0;
        total_acc = '0;
    endfunction

    // ---------------- stimulus ----------------

    function automatic dir_row_t add_row(int setup, logic [31:0] value, logic [31:0] weight,
                                         bit cov, logic [31:0] fval);
        dir_row_t r;
        r = '{setup: setup, cmd: 1'b0, value: value, weight: weight, covered: cov, fval: fval,
              typed: 1'b0, typed_bin: 0, typed_total: '0, typed_grand: '0};
        return r;
    endfunction

    function automatic dir_row_t readout_row(int setup, int tbin, logic [47:0] ttotal,
                                             logic [55:0] tgrand);
        dir_row_t r;
        r = '{setup: setup, cmd: 1'b1, value: $urandom(), weight: $urandom(),
              covered: 1'b0, fval: $urandom(), typed: 1'b1, typed_bin: tbin,
              typed_total: ttotal, typed_grand: tgrand};
        return r;
    endfunction

    function automatic void queue_row(dir_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic logic [31:0] pick_value();
        logic [63:0] span;
        logic [31:0] v;
        if ($urandom_range(0, 4) == 0) return $urandom();
        if (shadow_cfg.inv_bin_width == 0)
            span = 64'h4_0000;
        else
            span = ((64'(active_bins()) + 64'd1) << 32) / 64'(shadow_cfg.inv_bin_width);
        if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
        v = shadow_cfg.low_bound + $urandom_range(0, span[31:0]);
        if ($urandom_range(0, 3) == 0) v = v - $urandom_range(0, span[31:0] / 8 + 1);
        return v;
    endfunction

    function automatic logic [31:0] pick_filter_value();
        logic signed [33:0] diff;
        logic [31:0]        fl;
        logic [31:0]        fh;
        fl = shadow_cfg.filter_low;
        fh = shadow_cfg.filter_high;
        diff = $signed({{2{fh[31]}}, fh}) - $signed({{2{fl[31]}}, fl});
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return fl;
            2: return fh;
            3: return fl - 1;
            4: return fh + 1;
            default: begin
                if (diff >= 0 && diff <= 34'sh7FFF_FFFF)
                    return fl + $urandom_range(0, diff[31:0]);
                return $urandom_range(0, 32'h6_0000) - 32'h3_0000;
            end
        endcase
    endfunction

    // n_new returns how many results the item added to the expected queue
    task automatic send_item(input bit cmd, input logic [31:0] value, input logic [31:0] weight,
                             input bit cov, input logic [31:0] fval, output int n_new);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_sample_value  <= value;
        s_sample_weight <= weight;
        s_covered       <= cov;
        s_filter_value  <= fval;
        do @(posedge aclk); while (!s_ready);
        n_new = report_q.size();
        if (cmd) sweep_bins();
        else bin_sample(value, weight, cov, fval);
        n_new = report_q.size() - n_new;
        item_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        shadow_write(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // hold off until every readout is out, the bin sweep is done and the add pipe has emptied
    task automatic settle();
        s_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic apply_setup(input int id);
        case (id)
            SETUP_WIDE_WEIGHTED: begin
                write_reg(CFG_LOW_BOUND, 32'h7FFF_FFFF);
                write_reg(CFG_INV_BIN_WIDTH, 32'h0000_0000);
                write_reg(CFG_NUM_BINS, 32'hFFFF_FF01);
                write_reg(CFG_USE_WEIGHT, 32'h0000_0001);
                write_reg(CFG_FILTER_ENABLE, 32'h8000_0001);
                write_reg(CFG_FILTER_LOW, 32'hFFFF_0000);
                write_reg(CFG_FILTER_HIGH, 32'h0001_0000);
            end
            SETUP_EMPTY_FILTER: begin
                // low above high, and a bin count field of zero
                write_reg(CFG_FILTER_LOW, 32'h0001_0000);
                write_reg(CFG_FILTER_HIGH, 32'hFFFF_0000);
                write_reg(CFG_NUM_BINS, 32'h0000_0080);
                write_reg(CFG_USE_WEIGHT, 32'hFFFF_FFFE);
                write_reg(CFG_IDX_W'(CFG_FILTER_HIGH + 1), 32'hFFFF_FFFF);
            end
            default: ;
        endcase
    endtask

    task automatic randomize_setup(input int phase);
        logic [31:0] low;
        logic [31:0] inv;
        logic [6:0]  nb;
        logic [31:0] fl;
        logic [31:0] fh;
        int          r;
        case (phase)
            0: begin low = 32'h8000_0000; inv = 32'hFFFF_FFFF; nb = 7'd64; end
            1: begin low = 32'h7FFF_FFFF; inv = 32'h0000_0001; nb = 7'd127; end
            default: begin
                r = $urandom_range(0, 19);
                nb = (r == 0) ? 7'd0 : (r == 1) ? 7'($urandom_range(65, 127)) :
                     (r < 4) ? 7'd64 : 7'($urandom_range(1, 16));
                r = $urandom_range(0, 19);
                low = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7FFF_FFFF :
                      (r == 2) ? $urandom() : $urandom_range(0, 32'h6_0000) - 32'h3_0000;
                r = $urandom_range(0, 19);
                inv = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF :
                      (r == 2) ? $urandom() : $urandom_range(32'h4000, 32'h8_0000);
            end
        endcase
        r = $urandom_range(0, 19);
        fl = $urandom_range(0, 32'h4_0000) - 32'h2_0000;
        if (r == 0) begin
            fl = 32'h8000_0000;
            fh = 32'h7FFF_FFFF;
        end else if (r < 4) begin
            fh = fl - $urandom_range(1, 32'h1_0000);
        end else begin
            fh = fl + $urandom_range(0, 32'h4_0000);
        end
        write_reg(CFG_LOW_BOUND, low);
        write_reg(CFG_INV_BIN_WIDTH, inv);
        write_reg(CFG_NUM_BINS, ($urandom() & ~32'h7F) | 32'(nb));
        write_reg(CFG_USE_WEIGHT, $urandom());
        write_reg(CFG_FILTER_ENABLE, $urandom());
        write_reg(CFG_FILTER_LOW, fl);
        write_reg(CFG_FILTER_HIGH, fh);
        if ($urandom_range(0, 4) == 0)
            write_reg(CFG_IDX_W'(CFG_FILTER_HIGH + 1 + $urandom_range(0, 248)), $urandom());
    endtask

    task automatic random_add();
        logic [31:0] w;
        int          n_new;
        case ($urandom_range(0, 9))
            0:       w = 32'h0;
            1:       w = 32'hFFFF_FFFF;
            default: w = $urandom();
        endcase
        send_item(1'b0, pick_value(), w, ($urandom_range(0, 9) == 0), pick_filter_value(),
                  n_new);
    endtask

    // ---------------- result checking ----------------

    always @(posedge aclk) begin : check_results
        bin_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (report_q.size() == 0) begin
                $error("unexpected result transfer: bin_index %0d bin_total %0h",
                       m_bin_index, m_bin_total);
                mismatches++;
            end else begin
                want = report_q.pop_front();
                if (m_bin_index !== want.bin_index) begin
                    $error("bin_index expected %0d actual %0d", want.bin_index, m_bin_index);
                    mismatches++;
                end
                if (m_bin_total !== want.bin_total) begin
                    $error("bin_total expected %0h actual %0h", want.bin_total, m_bin_total);
                    mismatches++;
                end
                if (m_grand_total !== want.grand_total) begin
                    $error("grand_total expected %0h actual %0h",
                           want.grand_total, m_grand_total);
                    mismatches++;
                end
                if (m_last !== want.last) begin
                    $error("last expected %0b actual %0b", want.last, m_last);
                    mismatches++;
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        bin_report_t tmp;
        dir_row_t    row;
        int          n_new;
        int          first;
        int          n;
        int          phase;

        shadow_cfg.low_bound       = '0;
        shadow_cfg.inv_bin_width   = 32'h0001_0000;
        shadow_cfg.num_bins        = 7'd64;
        shadow_cfg.use_weight      = 1'b0;
        shadow_cfg.filter_enable   = 1'b0;
        shadow_cfg.filter_low      = '0;
        shadow_cfg.filter_high     = '0;
        for (int k = 0; k < MAX_BINS; k++) bin_acc[k] = '0;
        total_acc = '0;

        // reset defaults: unit bins from zero, 64 bins, unweighted, filter off
        queue_row(add_row(SETUP_NONE, 32'h0000_0000, 32'h1234_5678, 1'b0, 32'h0));
        queue_row(add_row(SETUP_NONE, 32'h0000_8000, 32'h0, 1'b0, 32'h0));
        queue_row(add_row(SETUP_NONE, 32'h0005_0000, 32'h0, 1'b0, 32'h0));
        queue_row(add_row(SETUP_NONE, 32'h003F_FFFF, 32'h0, 1'b0, 32'h0));
        queue_row(add_row(SETUP_NONE, 32'h0040_0000, 32'h0, 1'b0, 32'h0));
        queue_row(add_row(SETUP_NONE, 32'h0041_0000, 32'h0, 1'b0, 32'h0));
        queue_row(add_row(SETUP_NONE, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0));
        queue_row(add_row(SETUP_NONE, 32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0));
        queue_row(add_row(SETUP_NONE, 32'h0001_0000, 32'h0, 1'b1, 32'h0));
        queue_row(add_row(SETUP_NONE, 32'h0002_0000, 32'hFFFF_FFFF, 1'b0,
                          32'h8000_0000));
        queue_row(readout_row(SETUP_NONE, 0, 48'h2_0000, 56'h6_0000));
        queue_row(readout_row(SETUP_NONE, 0, 48'h0, 56'h0));
        // single bin, zero reciprocal, weighted, filter on [-1.0, 1.0]
        queue_row(add_row(SETUP_WIDE_WEIGHTED, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0,
                          32'h0));
        queue_row(add_row(SETUP_NONE, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0,
                          32'h0001_0000));
        queue_row(add_row(SETUP_NONE, 32'h0, 32'h1, 1'b0, 32'hFFFF_0000));
        queue_row(add_row(SETUP_NONE, 32'h0, 32'h5, 1'b0, 32'h0001_0001));
        queue_row(add_row(SETUP_NONE, 32'h0, 32'h5, 1'b0, 32'h8000_0000));
        queue_row(add_row(SETUP_NONE, 32'h0, 32'h5, 1'b0, 32'h7FFF_FFFF));
        queue_row(add_row(SETUP_NONE, 32'h0, 32'h5, 1'b1, 32'h0));
        queue_row(readout_row(SETUP_NONE, 0, 48'h1_FFFF_FFFF, 56'h1_FFFF_FFFF));
        // empty filter range, bin count field zero
        queue_row(add_row(SETUP_EMPTY_FILTER, 32'h0, 32'h0, 1'b0, 32'h0));
        queue_row(add_row(SETUP_NONE, 32'h0, 32'h0, 1'b0, 32'h0001_0000));
        queue_row(readout_row(SETUP_NONE, 0, 48'h0, 56'h0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.setup != SETUP_NONE) begin
                settle();
                apply_setup(row.setup);
            end
            send_item(row.cmd, row.value, row.weight, row.covered, row.fval, n_new);
            if (row.typed) begin
                first = report_q.size() - n_new;
                for (int k = first; k < report_q.size(); k++) begin
                    tmp = report_q[k];
                    tmp.grand_total = row.typed_grand;
                    if (k - first == row.typed_bin) tmp.bin_total = row.typed_total;
                    report_q[k] = tmp;
                end
            end
        end

        phase = 0;
        while (item_count < ITEM_TARGET) begin
            if (item_count < 110) begin
                s_idle_pct = 24;
                m_idle_pct = 87;
            end else if (item_count < 190) begin
                s_idle_pct = 87;
                m_idle_pct = 24;
            end else begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end
            settle();
            randomize_setup(phase);
            n = $urandom_range(6, 28);
            repeat (n) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(1'b1, $urandom(), $urandom(), 1'($urandom()), $urandom(), n_new);
                else
                    random_add();
            end
            send_item(1'b1, $urandom(), $urandom(), 1'($urandom()), $urandom(), n_new);
            phase++;
        end

        settle();
        if (mismatches == 0)
            $display("PASS filtered_weighted_histogram");
        else
            $display("FAIL filtered_weighted_histogram");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/fwh_pkg.sv
hw/rtl/fwh_ram.sv
hw/rtl/fwh_index_pipe.sv
hw/rtl/fwh_accum.sv
hw/rtl/filtered_weighted_histogram.sv
verif/tb.sv
